[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[src/tksd_pkg.sv]
// ----------------------------------------------------------------------------
// tksd_pkg
// Key codes, character constants and the per-position decode function of the
// terminal key sequence decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tksd_pkg;

    typedef enum logic [3:0] {
        KIND_VALUE = 4'd0,
        KIND_ESC   = 4'd1,
        KIND_ENTER = 4'd2,
        KIND_TAB   = 4'd3,
        KIND_BKSP  = 4'd4,
        KIND_UP    = 4'd5,
        KIND_DOWN  = 4'd6,
        KIND_RIGHT = 4'd7,
        KIND_LEFT  = 4'd8,
        KIND_HOME  = 4'd9,
        KIND_END   = 4'd10,
        KIND_BTAB  = 4'd11,
        KIND_INS   = 4'd12,
        KIND_DEL   = 4'd13,
        KIND_PGUP  = 4'd14,
        KIND_PGDN  = 4'd15
    } t_key_kind;

    localparam int NUM_IN_BYTES = 8;
    localparam int LOOKAHEAD    = 5;

    localparam logic [7:0] CH_NUL         = 8'd0;
    localparam logic [7:0] CH_BS          = 8'd8;
    localparam logic [7:0] CH_TAB         = 8'd9;
    localparam logic [7:0] CH_LF          = 8'd10;
    localparam logic [7:0] CH_CR          = 8'd13;
    localparam logic [7:0] CH_ESC         = 8'd27;
    localparam logic [7:0] CH_DEL         = 8'd127;
    localparam logic [7:0] CTRL_FIRST     = 8'd1;
    localparam logic [7:0] CTRL_LAST      = 8'd26;
    localparam logic [7:0] CTRL_TO_LETTER = 8'h60;
    localparam logic [7:0] CH_LBRACKET    = "[";
    localparam logic [7:0] CH_SS3         = "O";
    localparam logic [7:0] CH_TILDE       = "~";
    localparam logic [7:0] CH_SEMI        = ";";
    localparam logic [7:0] CH_UP          = "A";
    localparam logic [7:0] CH_DOWN        = "B";
    localparam logic [7:0] CH_RIGHT       = "C";
    localparam logic [7:0] CH_LEFT        = "D";
    localparam logic [7:0] CH_HOME        = "H";
    localparam logic [7:0] CH_END         = "F";
    localparam logic [7:0] CH_BACKTAB     = "Z";
    localparam logic [7:0] CH_1           = "1";
    localparam logic [7:0] CH_2           = "2";
    localparam logic [7:0] CH_3           = "3";
    localparam logic [7:0] CH_4           = "4";
    localparam logic [7:0] CH_5           = "5";
    localparam logic [7:0] CH_6           = "6";
    localparam logic [7:0] CH_7           = "7";
    localparam logic [7:0] CH_8           = "8";
    localparam logic [7:0] MOD_SHIFT      = "2";
    localparam logic [7:0] MOD_ALT        = "3";
    localparam logic [7:0] MOD_CTRL       = "5";
    localparam logic [7:0] MOD_CTRL_SHIFT = "6";

    // decode of one window position; term clear means ESC prefix, look further
    typedef struct packed {
        t_key_kind   kind;
        logic [7:0]  chr;
        logic        ctrl;
        logic        alt;
        logic        shift;
        logic [2:0]  used;
        logic        term;
    } t_loc;

    function automatic t_key_kind arrow_kind(input logic [7:0] c);
        t_key_kind k;
        case (c)
            CH_UP:    k = KIND_UP;
            CH_DOWN:  k = KIND_DOWN;
            CH_RIGHT: k = KIND_RIGHT;
            CH_LEFT:  k = KIND_LEFT;
            default:  k = KIND_VALUE;
        endcase
        return k;
    endfunction

    function automatic t_loc local_decode(input logic [7:0] c0, input logic [7:0] c1,
                                          input logic [7:0] c2, input logic [7:0] c3,
                                          input logic [7:0] c4, input logic [7:0] c5);
        t_loc      r;
        t_key_kind a2;
        t_key_kind a5;
        logic      csi;
        r       = '0;
        r.kind  = KIND_VALUE;
        r.term  = 1'b1;
        a2      = arrow_kind(c2);
        a5      = arrow_kind(c5);
        csi     = (c1 == CH_LBRACKET);
        if (c0 == CH_ESC) begin
            if (c1 == CH_NUL) begin
                r.kind = KIND_ESC;
                r.used = 3'd1;
            end else if (csi && a2 != KIND_VALUE) begin
                r.kind = a2;
                r.used = 3'd3;
            end else if (csi && c2 == CH_HOME) begin
                r.kind = KIND_HOME;
                r.used = 3'd3;
            end else if (csi && c2 == CH_END) begin
                r.kind = KIND_END;
                r.used = 3'd3;
            end else if (csi && c2 == CH_BACKTAB) begin
                r.kind  = KIND_BTAB;
                r.shift = 1'b1;
                r.used  = 3'd3;
            end else if (csi && c3 == CH_TILDE && (c2 inside {CH_1, CH_7})) begin
                r.kind = KIND_HOME;
                r.used = 3'd4;
            end else if (csi && c3 == CH_TILDE && (c2 inside {CH_4, CH_8})) begin
                r.kind = KIND_END;
                r.used = 3'd4;
            end else if (csi && c3 == CH_TILDE && c2 == CH_2) begin
                r.kind = KIND_INS;
                r.used = 3'd4;
            end else if (csi && c3 == CH_TILDE && c2 == CH_3) begin
                r.kind = KIND_DEL;
                r.used = 3'd4;
            end else if (csi && c3 == CH_TILDE && c2 == CH_5) begin
                r.kind = KIND_PGUP;
                r.used = 3'd4;
            end else if (csi && c3 == CH_TILDE && c2 == CH_6) begin
                r.kind = KIND_PGDN;
                r.used = 3'd4;
            end else if (csi && c2 == CH_1 && c3 == CH_SEMI && a5 != KIND_VALUE &&
                         (c4 inside {MOD_SHIFT, MOD_ALT, MOD_CTRL, MOD_CTRL_SHIFT})) begin
                r.kind  = a5;
                r.used  = 3'd6;
                r.shift = (c4 inside {MOD_SHIFT, MOD_CTRL_SHIFT});
                r.alt   = (c4 == MOD_ALT);
                r.ctrl  = (c4 inside {MOD_CTRL, MOD_CTRL_SHIFT});
            end else if (c1 == CH_SS3 && c2 == CH_HOME) begin
                r.kind = KIND_HOME;
                r.used = 3'd3;
            end else if (c1 == CH_SS3 && c2 == CH_END) begin
                r.kind = KIND_END;
                r.used = 3'd3;
            end else begin
                r.term = 1'b0;
            end
        end else begin
            case (c0) inside
                CH_NUL: begin
                    r.chr = CH_NUL;
                end
                CH_LF, CH_CR: begin
                    r.kind = KIND_ENTER;
                    r.used = 3'd1;
                end
                CH_TAB: begin
                    r.kind = KIND_TAB;
                    r.used = 3'd1;
                end
                CH_BS, CH_DEL: begin
                    r.kind = KIND_BKSP;
                    r.used = 3'd1;
                end
                [CTRL_FIRST:CTRL_LAST]: begin
                    r.chr  = c0 + CTRL_TO_LETTER;
                    r.ctrl = 1'b1;
                    r.used = 3'd1;
                end
                default: begin
                    r.chr = c0;
                end
            endcase
        end
        return r;
    endfunction

endpackage

[src/terminal_key_sequence_decoder_core.sv]
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder_core
// Decodes one terminal key from the start of a window of input bytes.
// Throughput: one word per cycle when the output is not stalled; four
// register stages (mask, per-position decode, ESC-chain select,
// count/output) each hand on a word every cycle unless back-pressure
// from i_m_axis_tready holds it.
// Reset: synchronous active-low i_rst_n empties all stages; no other state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module terminal_key_sequence_decoder_core #(
    parameter int WINDOW_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // byte0 .. byte7, byte0 lowest
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // char_value, ctrl, alt, shift, bytes_used, zero
    output logic [3:0]  o_m_axis_tuser    // key_kind
);

    localparam int IN_BYTES = tksd_pkg::NUM_IN_BYTES;
    localparam int EXT_BYTES = (WINDOW_BYTES > IN_BYTES) ? WINDOW_BYTES : IN_BYTES;
    localparam int PAD_BYTES = WINDOW_BYTES + tksd_pkg::LOOKAHEAD;
    localparam int PW = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;

    logic en1, en2, en3, en4;
    logic r_v1, r_v2, r_v3, r_v4;

    logic [8*EXT_BYTES-1:0] ext_data;
    logic [7:0]             n_s1 [WINDOW_BYTES];
    logic [7:0]             r_s1 [WINDOW_BYTES];
    logic [7:0]             pad  [PAD_BYTES];
    tksd_pkg::t_loc         n_loc2 [WINDOW_BYTES];
    tksd_pkg::t_loc         r_loc2 [WINDOW_BYTES];
    tksd_pkg::t_loc         n_sel3;
    tksd_pkg::t_loc         r_sel3;
    logic [PW-1:0]          n_p3;
    logic [PW-1:0]          r_p3;
    logic [2:0]             used_m;
    logic [4:0]             used_sum;
    logic [3:0]             n_used4;
    logic                   n_alt4;
    logic [15:0]            r_tdata4;
    logic [3:0]             r_tuser4;

    // advance a stage when it is empty or its successor advances
    assign en4             = !r_v4 || i_m_axis_tready;
    assign en3             = !r_v3 || en4;
    assign en2             = !r_v2 || en3;
    assign en1             = !r_v1 || en2;
    assign o_s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // stage 1: cut the window at the first zero byte
    assign ext_data = (8*EXT_BYTES)'(i_s_axis_tdata);

    always_comb begin
        logic       ended;
        logic [7:0] b;
        ended = 1'b0;
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            b       = ext_data[8*i +: 8];
            ended   = ended || (b == tksd_pkg::CH_NUL);
            n_s1[i] = ended ? tksd_pkg::CH_NUL : b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= n_s1;
        end
    end

    // stage 2: decode every position independently
    always_comb begin
        for (int i = 0; i < PAD_BYTES; i++) begin
            pad[i] = (i < WINDOW_BYTES) ? r_s1[(i < WINDOW_BYTES) ? i : 0] : tksd_pkg::CH_NUL;
        end
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            n_loc2[i] = tksd_pkg::local_decode(pad[i], pad[i+1], pad[i+2],
                                               pad[i+3], pad[i+4], pad[i+5]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_loc2 <= n_loc2;
        end
    end

    // stage 3: pick the first position past the ESC prefix chain
    always_comb begin
        logic found;
        found  = 1'b0;
        n_sel3 = r_loc2[0];
        n_p3   = '0;
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            if (!found && r_loc2[i].term) begin
                found  = 1'b1;
                n_sel3 = r_loc2[i];
                n_p3   = PW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_sel3 <= n_sel3;
            r_p3   <= n_p3;
        end
    end

    // stage 4: add the prefix count, saturate, drive the output register
    assign used_m   = (r_sel3.used == 3'd0) ? 3'd1 : r_sel3.used;
    assign used_sum = 5'(used_m) + 5'(r_p3);
    assign n_used4  = (r_p3 == '0) ? 4'(r_sel3.used)
                    : ((used_sum > 5'd15) ? 4'd15 : used_sum[3:0]);
    assign n_alt4   = r_sel3.alt || (r_p3 != '0);

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_tdata4 <= {1'b0, n_used4, r_sel3.shift, n_alt4, r_sel3.ctrl, r_sel3.chr};
            r_tuser4 <= r_sel3.kind;
        end
    end

    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = r_tdata4;
    assign o_m_axis_tuser  = r_tuser4;

    `ASSERT_IMPLIES(a_ready_when_out_empty, i_clk, i_rst_n, !r_v4, o_s_axis_tready)
    `ASSERT_NEXT(a_stage3_loads, i_clk, i_rst_n, r_v2 && en3, r_v3)
    `ASSERT_IMPLIES(a_zero_count_plain, i_clk, i_rst_n,
                    o_m_axis_tvalid && o_m_axis_tdata[14:11] == 4'd0,
                    o_m_axis_tuser == tksd_pkg::KIND_VALUE && o_m_axis_tdata[10:8] == 3'd0)
    `ASSERT_IMPLIES(a_special_no_char, i_clk, i_rst_n,
                    o_m_axis_tvalid && o_m_axis_tuser != tksd_pkg::KIND_VALUE,
                    o_m_axis_tdata[7:0] == 8'd0)

endmodule

[tb/tb_terminal_key_sequence_decoder_core.sv]
// ----------------------------------------------------------------------------
// tb_terminal_key_sequence_decoder_core
// Streams windows of terminal input bytes into the key decoder and checks
// every result word, field by field, against a decode of the same window
// computed here. Covers each key form, ESC chains and broken sequences, then
// random windows with random gaps and stalls on both sides, a long output
// stall that backs up the input, and back-to-back traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_terminal_key_sequence_decoder_core;

    typedef struct packed {
        tksd_pkg::t_key_kind kind;
        logic [7:0]          chr;
        logic                ctrl;
        logic                alt;
        logic                shift;
        logic [3:0]          used;
    } t_key_result;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;

    t_key_result expected_keys[$];
    int          error_count = 0;
    bit          src_gaps    = 1'b1;
    bit          sink_gaps   = 1'b1;
    int          sink_hold   = 0;

    terminal_key_sequence_decoder_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #(5_000_000);
        $display("tb_terminal_key_sequence_decoder_core: done, errors");
        $finish;
    end

    function automatic tksd_pkg::t_key_kind arrow_of(input logic [7:0] c);
        case (c)
            tksd_pkg::CH_UP:    return tksd_pkg::KIND_UP;
            tksd_pkg::CH_DOWN:  return tksd_pkg::KIND_DOWN;
            tksd_pkg::CH_RIGHT: return tksd_pkg::KIND_RIGHT;
            tksd_pkg::CH_LEFT:  return tksd_pkg::KIND_LEFT;
            default:            return tksd_pkg::KIND_VALUE;
        endcase
    endfunction

    // CSI body after ESC [; used is zero when nothing matches
    function automatic t_key_result csi_key(input logic [7:0] c, input logic [7:0] t,
                                            input logic [7:0] m, input logic [7:0] f);
        t_key_result r;
        r = '0;
        if (arrow_of(c) != tksd_pkg::KIND_VALUE) begin
            r.kind = arrow_of(c);
            r.used = 4'd3;
        end else if (c == tksd_pkg::CH_HOME) begin
            r.kind = tksd_pkg::KIND_HOME;
            r.used = 4'd3;
        end else if (c == tksd_pkg::CH_END) begin
            r.kind = tksd_pkg::KIND_END;
            r.used = 4'd3;
        end else if (c == tksd_pkg::CH_BACKTAB) begin
            r.kind  = tksd_pkg::KIND_BTAB;
            r.shift = 1'b1;
            r.used  = 4'd3;
        end else if (t == tksd_pkg::CH_TILDE) begin
            case (c)
                tksd_pkg::CH_1, tksd_pkg::CH_7: r.kind = tksd_pkg::KIND_HOME;
                tksd_pkg::CH_4, tksd_pkg::CH_8: r.kind = tksd_pkg::KIND_END;
                tksd_pkg::CH_2:                 r.kind = tksd_pkg::KIND_INS;
                tksd_pkg::CH_3:                 r.kind = tksd_pkg::KIND_DEL;
                tksd_pkg::CH_5:                 r.kind = tksd_pkg::KIND_PGUP;
                tksd_pkg::CH_6:                 r.kind = tksd_pkg::KIND_PGDN;
                default:                        r.kind = tksd_pkg::KIND_VALUE;
            endcase
            if (r.kind != tksd_pkg::KIND_VALUE)
                r.used = 4'd4;
        end else if (c == tksd_pkg::CH_1 && t == tksd_pkg::CH_SEMI &&
                     arrow_of(f) != tksd_pkg::KIND_VALUE &&
                     (m inside {tksd_pkg::MOD_SHIFT, tksd_pkg::MOD_ALT,
                                tksd_pkg::MOD_CTRL, tksd_pkg::MOD_CTRL_SHIFT})) begin
            r.kind  = arrow_of(f);
            r.shift = (m inside {tksd_pkg::MOD_SHIFT, tksd_pkg::MOD_CTRL_SHIFT});
            r.alt   = (m == tksd_pkg::MOD_ALT);
            r.ctrl  = (m inside {tksd_pkg::MOD_CTRL, tksd_pkg::MOD_CTRL_SHIFT});
            r.used  = 4'd6;
        end
        return r;
    endfunction

    function automatic t_key_result decode_key(input logic [63:0] w);
        logic [7:0]  s [16];
        t_key_result r;
        logic        ended;
        logic        hit;
        logic [7:0]  c;
        int          p;
        int          esc_prefixes;
        int          cnt;
        int          i;
        ended = 1'b0;
        for (i = 0; i < 16; i++)
            s[i] = tksd_pkg::CH_NUL;
        for (i = 0; i < tksd_pkg::NUM_IN_BYTES; i++) begin
            if (w[8*i +: 8] == tksd_pkg::CH_NUL)
                ended = 1'b1;
            s[i] = ended ? tksd_pkg::CH_NUL : w[8*i +: 8];
        end
        p            = 0;
        esc_prefixes = 0;
        hit          = 1'b0;
        r            = '0;
        while (!hit) begin
            c   = s[p];
            r   = '0;
            hit = 1'b1;
            if (c == tksd_pkg::CH_ESC) begin
                if (s[p+1] == tksd_pkg::CH_NUL) begin
                    r.kind = tksd_pkg::KIND_ESC;
                    r.used = 4'd1;
                end else begin
                    if (s[p+1] == tksd_pkg::CH_LBRACKET)
                        r = csi_key(s[p+2], s[p+3], s[p+4], s[p+5]);
                    else if (s[p+1] == tksd_pkg::CH_SS3 && s[p+2] == tksd_pkg::CH_HOME) begin
                        r.kind = tksd_pkg::KIND_HOME;
                        r.used = 4'd3;
                    end else if (s[p+1] == tksd_pkg::CH_SS3 &&
                                 s[p+2] == tksd_pkg::CH_END) begin
                        r.kind = tksd_pkg::KIND_END;
                        r.used = 4'd3;
                    end
                    if (r.used == 4'd0) begin
                        hit = 1'b0;
                        esc_prefixes++;
                        p++;
                    end
                end
            end else begin
                case (c)
                    tksd_pkg::CH_NUL: ;
                    tksd_pkg::CH_LF, tksd_pkg::CH_CR: begin
                        r.kind = tksd_pkg::KIND_ENTER;
                        r.used = 4'd1;
                    end
                    tksd_pkg::CH_TAB: begin
                        r.kind = tksd_pkg::KIND_TAB;
                        r.used = 4'd1;
                    end
                    tksd_pkg::CH_BS, tksd_pkg::CH_DEL: begin
                        r.kind = tksd_pkg::KIND_BKSP;
                        r.used = 4'd1;
                    end
                    default: begin
                        if (c inside {[tksd_pkg::CTRL_FIRST:tksd_pkg::CTRL_LAST]}) begin
                            r.chr  = c + tksd_pkg::CTRL_TO_LETTER;
                            r.ctrl = 1'b1;
                            r.used = 4'd1;
                        end else begin
                            r.chr = c;
                        end
                    end
                endcase
            end
        end
        cnt = int'(r.used);
        for (i = 0; i < esc_prefixes; i++) begin
            r.alt = 1'b1;
            cnt   = (cnt > 0 ? cnt : 1) + 1;
        end
        r.used = (cnt > 15) ? 4'd15 : cnt[3:0];
        return r;
    endfunction

    function automatic logic [63:0] window_of(input string txt);
        logic [63:0] w;
        int          i;
        w = '0;
        for (i = 0; i < txt.len() && i < tksd_pkg::NUM_IN_BYTES; i++)
            w[8*i +: 8] = txt[i];
        return w;
    endfunction

    function automatic logic [63:0] random_window();
        logic [7:0]  b [16];
        logic [63:0] w;
        string       finals;
        int          p;
        int          n;
        int          i;
        finals = "ABCDHFZ";
        for (i = 0; i < 16; i++)
            b[i] = 8'($urandom_range(0, 255));
        p = 0;
        n = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0;
        for (i = 0; i < n; i++) begin
            b[p] = tksd_pkg::CH_ESC;
            p++;
        end
        case ($urandom_range(0, 10))
            0, 1: begin
                b[p]   = tksd_pkg::CH_ESC;
                b[p+1] = tksd_pkg::CH_LBRACKET;
                b[p+2] = finals[$urandom_range(0, 6)];
            end
            2, 3: begin
                b[p]   = tksd_pkg::CH_ESC;
                b[p+1] = tksd_pkg::CH_LBRACKET;
                b[p+2] = 8'("0" + $urandom_range(0, 9));
                b[p+3] = tksd_pkg::CH_TILDE;
            end
            4, 5: begin
                b[p]   = tksd_pkg::CH_ESC;
                b[p+1] = tksd_pkg::CH_LBRACKET;
                b[p+2] = tksd_pkg::CH_1;
                b[p+3] = tksd_pkg::CH_SEMI;
                case ($urandom_range(0, 4))
                    0:       b[p+4] = tksd_pkg::MOD_SHIFT;
                    1:       b[p+4] = tksd_pkg::MOD_ALT;
                    2:       b[p+4] = tksd_pkg::MOD_CTRL;
                    3:       b[p+4] = tksd_pkg::MOD_CTRL_SHIFT;
                    default: b[p+4] = 8'("0" + $urandom_range(0, 9));
                endcase
                if ($urandom_range(0, 3) != 0)
                    b[p+5] = 8'(tksd_pkg::CH_UP + $urandom_range(0, 3));
            end
            6: begin
                b[p]   = tksd_pkg::CH_ESC;
                b[p+1] = tksd_pkg::CH_SS3;
                case ($urandom_range(0, 2))
                    0:       b[p+2] = tksd_pkg::CH_HOME;
                    1:       b[p+2] = tksd_pkg::CH_END;
                    default: ;
                endcase
            end
            7: b[p] = ($urandom_range(0, 7) == 0) ? tksd_pkg::CH_DEL
                                                  : 8'($urandom_range(1, 31));
            8: begin
                b[p]   = tksd_pkg::CH_ESC;
                b[p+1] = tksd_pkg::CH_NUL;
            end
            9: for (i = p; i < 16; i++) b[i] = tksd_pkg::CH_ESC;
            default: ;
        endcase
        if ($urandom_range(0, 4) == 0)
            b[$urandom_range(0, 7)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            b[$urandom_range(0, 7)] = tksd_pkg::CH_NUL;
        for (i = 0; i < tksd_pkg::NUM_IN_BYTES; i++)
            w[8*i +: 8] = b[i];
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        error_count++;
    endtask

    task automatic send_window(input logic [63:0] w);
        int gap;
        gap = src_gaps ? int'($urandom_range(0, 9)) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        expected_keys.push_back(decode_key(w));
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_keys.size() != 0) @(posedge i_clk);
    endtask

    initial begin : sink_ready
        int pause;
        forever begin
            pause     = sink_hold + (sink_gaps ? int'($urandom_range(0, 9)) : 0);
            sink_hold = 0;
            if (pause > 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_tvalid && i_rst_n) && sink_hold == 0) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_key_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_keys.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = expected_keys.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch($sformatf("key_kind got %0d want %0d", m_tuser, want.kind));
                if (m_tdata[7:0] !== want.chr)
                    report_mismatch($sformatf("char_value got %0d want %0d",
                                              m_tdata[7:0], want.chr));
                if (m_tdata[8] !== want.ctrl)
                    report_mismatch($sformatf("ctrl got %b want %b", m_tdata[8], want.ctrl));
                if (m_tdata[9] !== want.alt)
                    report_mismatch($sformatf("alt got %b want %b", m_tdata[9], want.alt));
                if (m_tdata[10] !== want.shift)
                    report_mismatch($sformatf("shift got %b want %b", m_tdata[10], want.shift));
                if (m_tdata[14:11] !== want.used)
                    report_mismatch($sformatf("bytes_used got %0d want %0d",
                                              m_tdata[14:11], want.used));
            end
        end
    end

    task automatic test_directed_keys();
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        send_window('0);
        send_window(window_of("a") | 64'hFFFF_FFFF_FF00_0000);
        send_window('1);
        send_window(window_of("\033"));
        send_window(window_of("\033[A"));
        send_window(window_of("\033[1;2B"));
        send_window(window_of("\033[1;3C"));
        send_window(window_of("\033[1;5D"));
        send_window(window_of("\033[1;6A"));
        send_window(window_of("\033[H"));
        send_window(window_of("\033[F"));
        send_window(window_of("\033[Z"));
        send_window(window_of("\033[1~"));
        send_window(window_of("\033[8~"));
        send_window(window_of("\033[2~"));
        send_window(window_of("\033[3~"));
        send_window(window_of("\033[5~"));
        send_window(window_of("\033[6~"));
        send_window(window_of("\033OH"));
        send_window(window_of("\033OF"));
        send_window(window_of("\015"));
        send_window(window_of("\t"));
        send_window(window_of("\177"));
        send_window(window_of("\032"));
        send_window({tksd_pkg::NUM_IN_BYTES{tksd_pkg::CH_ESC}});
        send_window(window_of("\033x"));
        send_window(window_of("\033[1;7A"));
    endtask

    task automatic test_random_keys(input int count);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        repeat (count) send_window(random_window());
    endtask

    task automatic test_back_to_back(input int count);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        repeat (count) send_window(random_window());
    endtask

    task automatic test_output_stall();
        src_gaps  = 1'b0;
        sink_gaps = 1'b1;
        sink_hold = 60;
        repeat (40) send_window(random_window());
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_keys();
        wait_for_results();
        test_random_keys(1000);
        wait_for_results();
        test_output_stall();
        wait_for_results();
        test_back_to_back(200);
        wait_for_results();
        test_output_stall();
        wait_for_results();
        repeat (12) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_terminal_key_sequence_decoder_core: done, clean");
        else
            $display("tb_terminal_key_sequence_decoder_core: done, errors");
        $finish;
    end

endmodule
